// File: rtl/core/csrmv_pkg.sv
// ----------------------------------------------------------------------------
// csrmv_pkg
// shared types and constants of the compressed-row sparse matrix-vector unit
// ----------------------------------------------------------------------------
package csrmv_pkg;

    // default sizes of the top-level parameters
    localparam int VECTOR_DEPTH_DEF   = 1024;
    localparam int ROW_COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int ROW_IDX_W = 16;
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 16;

    // queue between front and back
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
    localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

    // result queue at the back end
    localparam int RES_QUEUE_DEPTH = 8;
    localparam int RES_PTR_W       = $clog2(RES_QUEUE_DEPTH);
    localparam int RES_CNT_W       = $clog2(RES_QUEUE_DEPTH + 1);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] SUM_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SUM_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NONZERO = 2'd1,
        REQ_EMPTY   = 2'd2
    } req_t;

    typedef struct packed {
        req_t                    op;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    in_range;
    } cmd_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]    row_index;
        logic signed [VAL_W-1:0] row_sum;
        logic                    saturated;
    } res_t;

endpackage

// File: rtl/core/csr_sparse_matrix_vector.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector
// path: command queue, s1, s2 and s3 registers, result queue, then the result ports
// throughput: one input transaction per cycle while full is low, set by the
//   single vector read and one 32x32 multiply-accumulate per nonzero
// reset: rst_n clears queues, accumulator, overflow flag and row counter at once;
//   the vector store is not cleared and must be loaded before it is read
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector #(
    parameter int VECTOR_DEPTH   = csrmv_pkg::VECTOR_DEPTH_DEF,
    parameter int ROW_COUNT_BITS = csrmv_pkg::ROW_COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input queue side
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          req_type,
    input  logic [csrmv_pkg::IDX_W-1:0]         item_index,
    input  logic signed [csrmv_pkg::VAL_W-1:0]  item_value,
    input  logic                                last_in_row,
    // result queue side
    input  logic                                pop,
    output logic                                empty,
    output logic [csrmv_pkg::ROW_IDX_W-1:0]     row_index,
    output logic signed [csrmv_pkg::VAL_W-1:0]  row_sum,
    output logic                                saturated
);

    // front to back command queue
    logic            cmd_valid;
    csrmv_pkg::cmd_t cmd;
    logic            cmd_pop;
    csrmv_pkg::res_t res;

    // front end: takes a transaction per cycle unless full, drops unknown request
    // types, tags whether the index lies inside the vector store and queues it
    csrmv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .item_index  (item_index),
        .item_value  (item_value),
        .last_in_row (last_in_row),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // back end: vector store write or read, multiply, saturating accumulate,
    // floor shift and clamp of a finished row, then a result queue; it only
    // issues a command when a result slot is guaranteed, so the pipe never stalls
    csrmv_back #(
        .VECTOR_DEPTH   (VECTOR_DEPTH),
        .ROW_COUNT_BITS (ROW_COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_empty (empty),
        .res_pop   (pop),
        .res       (res)
    );

    // oldest waiting result transaction
    assign row_index = res.row_index;
    assign row_sum   = res.row_sum;
    assign saturated = res.saturated;

endmodule

// File: rtl/core/csrmv_ram.sv
// ----------------------------------------------------------------------------
// csrmv_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/csrmv_front.sv
// ----------------------------------------------------------------------------
// csrmv_front
// accepts input transactions, drops unknown types, tags range, queues commands
// ----------------------------------------------------------------------------
module csrmv_front #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        req_type,
    input  logic [csrmv_pkg::IDX_W-1:0]       item_index,
    input  logic signed [csrmv_pkg::VAL_W-1:0] item_value,
    input  logic                              last_in_row,
    output logic                              cmd_valid,
    output csrmv_pkg::cmd_t                   cmd,
    input  logic                              cmd_pop
);

    csrmv_pkg::cmd_t                   cmd_mem_reg [csrmv_pkg::CMD_QUEUE_DEPTH];
    logic [csrmv_pkg::CMD_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [csrmv_pkg::CMD_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [csrmv_pkg::CMD_CNT_W-1:0]   count_reg, count_next;
    csrmv_pkg::cmd_t                   cmd_in;
    logic                              keep_item;
    logic                              wr_en;

    // classify the incoming transaction
    always_comb
    begin
        keep_item = req_type inside {csrmv_pkg::REQ_LOAD, csrmv_pkg::REQ_NONZERO,
                                     csrmv_pkg::REQ_EMPTY};
        cmd_in.op       = csrmv_pkg::req_t'(req_type);
        cmd_in.index    = item_index;
        cmd_in.value    = item_value;
        cmd_in.last     = last_in_row;
        cmd_in.in_range = int'(item_index) < VECTOR_DEPTH;
    end

    assign full      = count_reg == csrmv_pkg::CMD_CNT_W'(csrmv_pkg::CMD_QUEUE_DEPTH);
    assign wr_en     = push && !full && keep_item;
    assign cmd_valid = count_reg != '0;
    assign cmd       = cmd_mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wr_en ? wptr_reg + csrmv_pkg::CMD_PTR_W'(1) : wptr_reg;
        rptr_next  = cmd_pop ? rptr_reg + csrmv_pkg::CMD_PTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (wr_en && !cmd_pop)
        begin
            count_next = count_reg + csrmv_pkg::CMD_CNT_W'(1);
        end
        else if (!wr_en && cmd_pop)
        begin
            count_next = count_reg - csrmv_pkg::CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cmd_mem_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/core/csrmv_back.sv
// ----------------------------------------------------------------------------
// csrmv_back
// vector store, multiply, saturating accumulate, narrowing and result queue
// ----------------------------------------------------------------------------
module csrmv_back #(
    parameter int VECTOR_DEPTH   = csrmv_pkg::VECTOR_DEPTH_DEF,
    parameter int ROW_COUNT_BITS = csrmv_pkg::ROW_COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  csrmv_pkg::cmd_t  cmd,
    output logic             cmd_pop,
    output logic             res_empty,
    input  logic             res_pop,
    output csrmv_pkg::res_t  res
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);

    // issue and vector store
    logic                               issue;
    logic                               ram_we;
    logic                               ram_re;
    logic [ADDR_W-1:0]                  ram_addr;
    logic [csrmv_pkg::VAL_W-1:0]        ram_rdata;

    // stage 1: command with vector data arriving
    logic                               s1_valid_reg;
    csrmv_pkg::cmd_t                    s1_cmd_reg;
    logic signed [csrmv_pkg::VAL_W-1:0] x_val;
    logic signed [csrmv_pkg::ACC_W-1:0] prod_w;

    // stage 2: product ready, accumulate
    logic                               s2_valid_reg;
    csrmv_pkg::req_t                    s2_op_reg;
    logic                               s2_last_reg;
    logic signed [csrmv_pkg::ACC_W-1:0] s2_prod_reg;

    logic signed [csrmv_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                               ovf_reg, ovf_next;
    logic [ROW_COUNT_BITS-1:0]          row_cnt_reg, row_cnt_next;
    logic signed [csrmv_pkg::ACC_W-1:0] sum_w;
    logic                               add_ovf;
    logic signed [csrmv_pkg::ACC_W-1:0] sat_sum;

    // stage 3: finished row, narrowing
    logic                               s3_load;
    logic                               s3_valid_reg;
    logic signed [csrmv_pkg::ACC_W-1:0] s3_acc_reg, s3_acc_next;
    logic                               s3_sat_reg, s3_sat_next;
    logic [csrmv_pkg::ROW_IDX_W-1:0]    s3_row_reg;
    logic signed [csrmv_pkg::ACC_W-1:0] shifted;
    logic [csrmv_pkg::ACC_W-csrmv_pkg::VAL_W:0] shifted_hi;
    logic                               clamp;
    csrmv_pkg::res_t                    res_in;

    // result queue
    csrmv_pkg::res_t                    res_mem_reg [csrmv_pkg::RES_QUEUE_DEPTH];
    logic [csrmv_pkg::RES_PTR_W-1:0]    res_wptr_reg;
    logic [csrmv_pkg::RES_PTR_W-1:0]    res_rptr_reg;
    logic [csrmv_pkg::RES_CNT_W-1:0]    res_count_reg, res_count_next;
    logic                               res_rd;

    // issue only when every command in flight is sure of a result slot
    assign issue = cmd_valid
        && (int'(res_count_reg) + int'(s1_valid_reg) + int'(s2_valid_reg)
            + int'(s3_valid_reg) < csrmv_pkg::RES_QUEUE_DEPTH);
    assign cmd_pop  = issue;
    assign ram_addr = ADDR_W'(cmd.index);
    assign ram_we   = issue && cmd.op == csrmv_pkg::REQ_LOAD && cmd.in_range;
    assign ram_re   = issue && cmd.op == csrmv_pkg::REQ_NONZERO;

    csrmv_ram #(
        .WIDTH (csrmv_pkg::VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (cmd.value),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // multiply, out-of-range column reads as zero
    always_comb
    begin
        x_val  = s1_cmd_reg.in_range ? $signed(ram_rdata) : '0;
        prod_w = s1_cmd_reg.value * x_val;
    end

    // saturating accumulate and row bookkeeping
    always_comb
    begin
        sum_w   = acc_reg + s2_prod_reg;
        add_ovf = (acc_reg[csrmv_pkg::ACC_W-1] == s2_prod_reg[csrmv_pkg::ACC_W-1])
            && (sum_w[csrmv_pkg::ACC_W-1] != acc_reg[csrmv_pkg::ACC_W-1]);
        if (add_ovf)
        begin
            sat_sum = s2_prod_reg[csrmv_pkg::ACC_W-1] ? csrmv_pkg::ACC_MIN
                                                      : csrmv_pkg::ACC_MAX;
        end
        else
        begin
            sat_sum = sum_w;
        end

        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        row_cnt_next = row_cnt_reg;
        s3_load      = 1'b0;
        s3_acc_next  = '0;
        s3_sat_next  = 1'b0;
        if (s2_valid_reg)
        begin
            case (s2_op_reg)
                csrmv_pkg::REQ_LOAD:
                begin
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    row_cnt_next = '0;
                end
                csrmv_pkg::REQ_NONZERO:
                begin
                    if (s2_last_reg)
                    begin
                        s3_load      = 1'b1;
                        s3_acc_next  = sat_sum;
                        s3_sat_next  = ovf_reg || add_ovf;
                        acc_next     = '0;
                        ovf_next     = 1'b0;
                        row_cnt_next = row_cnt_reg + ROW_COUNT_BITS'(1);
                    end
                    else
                    begin
                        acc_next = sat_sum;
                        ovf_next = ovf_reg || add_ovf;
                    end
                end
                csrmv_pkg::REQ_EMPTY:
                begin
                    s3_load      = 1'b1;
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    row_cnt_next = row_cnt_reg + ROW_COUNT_BITS'(1);
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // floor shift to q16.16 and clamp to 32 bits
    always_comb
    begin
        shifted    = s3_acc_reg >>> csrmv_pkg::FRAC_BITS;
        shifted_hi = shifted[csrmv_pkg::ACC_W-1:csrmv_pkg::VAL_W-1];
        clamp      = (shifted_hi != '0) && (shifted_hi != '1);
        res_in.row_index = s3_row_reg;
        res_in.saturated = s3_sat_reg || clamp;
        if (clamp)
        begin
            res_in.row_sum = s3_acc_reg[csrmv_pkg::ACC_W-1] ? csrmv_pkg::SUM_MIN
                                                            : csrmv_pkg::SUM_MAX;
        end
        else
        begin
            res_in.row_sum = shifted[csrmv_pkg::VAL_W-1:0];
        end
    end

    // result queue
    assign res_empty = res_count_reg == '0;
    assign res_rd    = res_pop && !res_empty;
    assign res       = res_mem_reg[res_rptr_reg];

    always_comb
    begin
        res_count_next = res_count_reg;
        if (s3_valid_reg && !res_rd)
        begin
            res_count_next = res_count_reg + csrmv_pkg::RES_CNT_W'(1);
        end
        else if (!s3_valid_reg && res_rd)
        begin
            res_count_next = res_count_reg - csrmv_pkg::RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            row_cnt_reg   <= '0;
            res_wptr_reg  <= '0;
            res_rptr_reg  <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s3_load;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            row_cnt_reg   <= row_cnt_next;
            res_count_reg <= res_count_next;
            if (s3_valid_reg)
            begin
                res_wptr_reg <= res_wptr_reg + csrmv_pkg::RES_PTR_W'(1);
            end
            if (res_rd)
            begin
                res_rptr_reg <= res_rptr_reg + csrmv_pkg::RES_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_cmd_reg <= cmd;
        end
        if (s1_valid_reg)
        begin
            s2_op_reg   <= s1_cmd_reg.op;
            s2_last_reg <= s1_cmd_reg.last;
            s2_prod_reg <= prod_w;
        end
        if (s3_load)
        begin
            s3_acc_reg <= s3_acc_next;
            s3_sat_reg <= s3_sat_next;
            s3_row_reg <= csrmv_pkg::ROW_IDX_W'(row_cnt_reg);
        end
        if (s3_valid_reg)
        begin
            res_mem_reg[res_wptr_reg] <= res_in;
        end
    end

endmodule
